// ----- hdl/mi3_pkg.sv -----
// Shared types, widths and saturation limits of the 3x3 matrix inverse unit.
`default_nettype none
package mi3_pkg;

  // Input element format: signed Q8.8.
  localparam int ELEM_W   = 16;
  localparam int FRAC     = 8;
  // Inverse element format: signed Q16.16.
  localparam int OUT_W    = 32;
  localparam int OUT_FRAC = OUT_W / 2;
  // Determinant output field width (Q24.24).
  localparam int DOUT_W   = 3 * ELEM_W;

  // Exact internal widths.
  localparam int PROD_W = 2 * ELEM_W;
  localparam int COF_W  = PROD_W + 1;
  localparam int DP_W   = ELEM_W + COF_W;
  localparam int DET_W  = DP_W + 2;
  localparam int SH     = FRAC + OUT_FRAC;
  localparam int NUM_W  = COF_W + SH;
  localparam int RW     = DET_W + 1;
  localparam int LANES  = 9;
  localparam int STEPS  = OUT_W;

  // Queue between front and back. It must cover the four front stages in
  // flight plus the entry waiting at its head, so that a steady stream of
  // beats never raises busy.
  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic signed [DET_W-1:0] DET_HI = DET_W'((longint'(1) <<< (DOUT_W - 1)) - 1);
  localparam logic signed [DET_W-1:0] DET_LO = -DET_HI - DET_W'(1);

  typedef struct packed {
    logic signed [ELEM_W-1:0] a00;
    logic signed [ELEM_W-1:0] a01;
    logic signed [ELEM_W-1:0] a02;
    logic signed [ELEM_W-1:0] a10;
    logic signed [ELEM_W-1:0] a11;
    logic signed [ELEM_W-1:0] a12;
    logic signed [ELEM_W-1:0] a20;
    logic signed [ELEM_W-1:0] a21;
    logic signed [ELEM_W-1:0] a22;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0]  inv00;
    logic signed [OUT_W-1:0]  inv01;
    logic signed [OUT_W-1:0]  inv02;
    logic signed [OUT_W-1:0]  inv10;
    logic signed [OUT_W-1:0]  inv11;
    logic signed [OUT_W-1:0]  inv12;
    logic signed [OUT_W-1:0]  inv20;
    logic signed [OUT_W-1:0]  inv21;
    logic signed [OUT_W-1:0]  inv22;
    logic signed [DOUT_W-1:0] determinant;
    logic                     singular;
  } out_t;

  // One classified matrix waiting for division. Lane r*3+c holds the
  // magnitude of the cofactor at row c, column r (the adjugate entry).
  typedef struct packed {
    logic [LANES-1:0][COF_W-1:0] cmag;
    logic [LANES-1:0]            neg;
    logic [DET_W-1:0]            dmag;
    logic signed [DOUT_W-1:0]    det_sat;
    logic                        singular;
  } qent_t;

endpackage
`default_nettype wire

// ----- hdl/matrix3x3_inverse_unit.sv -----
// Top level of the 3x3 matrix inverse unit: front, queue and divider back.
//
//  Channel   Direction  Handshake              Payload
//  input     in         start, busy            matrix (in_t, nine Q8.8 elements)
//  result    out        done (one-cycle beat)  result (out_t, Q16.16 inverse,
//                                              Q24.24 determinant, singular)
//
// A beat is taken at each rising edge where start is high and busy is low, so a
// new matrix may enter on every cycle. Each beat yields one result beat, after
// the four-stage cofactor and determinant pipeline, the queue and the 32-step
// divider pipeline with its output register (one quotient bit per stage in each
// of the nine lanes). Reset (rst, synchronous, active high) empties the
// pipelines and the queue; no clearing pass is needed. The receiver cannot
// stall: done is high for one cycle per result, and busy only rises if the
// queue could otherwise overflow.
`default_nettype none
module matrix3x3_inverse_unit (
  input  wire            clk,
  input  wire            rst,
  input  wire            start,
  output logic           busy,
  input  mi3_pkg::in_t   matrix,
  output logic           done,
  output mi3_pkg::out_t  result
);
  import mi3_pkg::*;

  logic              push;
  qent_t             push_entry;
  logic              q_valid;
  qent_t             q_head;
  logic [QCNT_W-1:0] q_count;

  // Front: multiplies out the cofactors and the determinant and classifies
  // the matrix (signs, magnitudes, singular test, saturated determinant).
  mi3_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .matrix  (matrix),
    .q_count (q_count),
    .busy    (busy),
    .push    (push),
    .entry   (push_entry)
  );

  // The back never stalls, so the head of the queue is taken whenever present.
  mi3_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (push),
    .wdata  (push_entry),
    .rd     (q_valid),
    .rvalid (q_valid),
    .rdata  (q_head),
    .count  (q_count)
  );

  // Back: one restoring divider lane per inverse element, then saturation.
  mi3_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_valid),
    .entry    (q_head),
    .done     (done),
    .res      (result)
  );

  // The queue is never written while it is full.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && q_count == QCNT_W'(QDEPTH)))
    else $error("queue written while full");

  // A singular result carries an all-zero inverse and determinant; the check covers inv00, inv01, inv11 and inv22.
  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.singular) |-> (result.determinant == '0 && result.inv00 == '0
      && result.inv11 == '0 && result.inv22 == '0 && result.inv01 == '0))
    else $error("singular result with non-zero fields");

  // A non-singular result never reports a zero determinant.
  a_det_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.singular) |-> (result.determinant != '0))
    else $error("non-singular result with zero determinant");

endmodule
`default_nettype wire

// ----- hdl/mi3_front.sv -----
// Front part: cofactors, determinant and classification of each matrix.
`default_nettype none
module mi3_front (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        start,
  input  mi3_pkg::in_t               matrix,
  input  wire [mi3_pkg::QCNT_W-1:0]  q_count,
  output logic                       busy,
  output logic                       push,
  output mi3_pkg::qent_t             entry
);
  import mi3_pkg::*;

  logic v1, v2, v3, v4;
  logic signed [ELEM_W-1:0] m [3][3];
  logic signed [PROD_W-1:0] pa [3][3];
  logic signed [PROD_W-1:0] pb [3][3];
  logic signed [ELEM_W-1:0] row1 [3];
  logic signed [ELEM_W-1:0] row2 [3];
  logic signed [COF_W-1:0]  cof [3][3];
  logic signed [DP_W-1:0]   dp [3];
  logic [LANES-1:0][COF_W-1:0] cmag3, cmag4;
  logic [LANES-1:0]            csign3, csign4;
  logic signed [DET_W-1:0]  det4;
  logic [QCNT_W:0]          credit_used;
  logic                     dneg;

  assign credit_used = {1'b0, q_count} + (QCNT_W+1)'(v1) + (QCNT_W+1)'(v2)
                     + (QCNT_W+1)'(v3) + (QCNT_W+1)'(v4);
  assign busy = credit_used >= (QCNT_W+1)'(QDEPTH);

  always_comb begin
    m[0][0] = matrix.a00; m[0][1] = matrix.a01; m[0][2] = matrix.a02;
    m[1][0] = matrix.a10; m[1][1] = matrix.a11; m[1][2] = matrix.a12;
    m[2][0] = matrix.a20; m[2][1] = matrix.a21; m[2][2] = matrix.a22;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        pa[r][c] <= m[(r == 2) ? 0 : r + 1][(c == 2) ? 0 : c + 1]
                  * m[(r == 0) ? 2 : r - 1][(c == 0) ? 2 : c - 1];
        pb[r][c] <= m[(r == 2) ? 0 : r + 1][(c == 0) ? 2 : c - 1]
                  * m[(r == 0) ? 2 : r - 1][(c == 2) ? 0 : c + 1];
        cof[r][c] <= COF_W'(pa[r][c]) - COF_W'(pb[r][c]);
      end
    end
    for (int c = 0; c < 3; c++) begin
      row1[c] <= m[0][c];
      row2[c] <= row1[c];
      dp[c]   <= row2[c] * cof[0][c];
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        csign3[r*3+c] <= cof[c][r][COF_W-1];
        cmag3[r*3+c]  <= cof[c][r][COF_W-1] ? COF_W'(-cof[c][r]) : COF_W'(cof[c][r]);
      end
    end
    det4   <= DET_W'(dp[0]) + DET_W'(dp[1]) + DET_W'(dp[2]);
    cmag4  <= cmag3;
    csign4 <= csign3;
  end

  assign dneg = det4[DET_W-1];
  assign push = v4;

  always_comb begin
    entry.cmag     = cmag4;
    entry.neg      = csign4 ^ {LANES{dneg}};
    entry.dmag     = dneg ? DET_W'(-det4) : DET_W'(det4);
    entry.singular = (det4 == '0);
    priority if (det4 > DET_HI) begin
      entry.det_sat = DOUT_W'(DET_HI);
    end else if (det4 < DET_LO) begin
      entry.det_sat = DOUT_W'(DET_LO);
    end else begin
      entry.det_sat = DOUT_W'(det4);
    end
  end

endmodule
`default_nettype wire

// ----- hdl/mi3_queue.sv -----
// Short queue that parts the classifying front from the dividing back.
`default_nettype none
module mi3_queue (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        wr,
  input  mi3_pkg::qent_t             wdata,
  input  wire                        rd,
  output logic                       rvalid,
  output mi3_pkg::qent_t             rdata,
  output logic [mi3_pkg::QCNT_W-1:0] count
);
  import mi3_pkg::*;

  qent_t              mem [QDEPTH];
  logic [QPTR_W-1:0]  wp, rp;
  logic               do_rd;

  assign rvalid = (count != '0);
  assign do_rd  = rd && rvalid;
  assign rdata  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wp <= (wp == QPTR_W'(QDEPTH - 1)) ? '0 : wp + QPTR_W'(1);
      end
      if (do_rd) begin
        rp <= (rp == QPTR_W'(QDEPTH - 1)) ? '0 : rp + QPTR_W'(1);
      end
      count <= count + QCNT_W'(wr) - QCNT_W'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/mi3_back.sv -----
// Back part: nine pipelined restoring dividers and output saturation.
`default_nettype none
module mi3_back (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  input  mi3_pkg::qent_t  entry,
  output logic            done,
  output mi3_pkg::out_t   res
);
  import mi3_pkg::*;

  logic                    vld  [STEPS+1];
  logic [RW-1:0]           rem  [STEPS+1][LANES];
  logic [OUT_W-1:0]        nlo  [STEPS+1][LANES];
  logic [OUT_W-1:0]        quo  [STEPS+1][LANES];
  logic [LANES-1:0]        ov   [STEPS+1];
  logic [LANES-1:0]        neg  [STEPS+1];
  logic [DET_W-1:0]        dv   [STEPS+1];
  logic signed [DOUT_W-1:0] dsat [STEPS+1];
  logic                    sing [STEPS+1];

  logic [RW-1:0]           trial [STEPS][LANES];
  logic                    ge    [STEPS][LANES];
  logic [NUM_W-1:0]        num   [LANES];
  logic [LANES-1:0][OUT_W-1:0] inv;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      num[l] = {entry.cmag[l], SH'(0)};
    end
    for (int k = 0; k < STEPS; k++) begin
      for (int l = 0; l < LANES; l++) begin
        trial[k][l] = {rem[k][l][RW-2:0], nlo[k][l][OUT_W-1]};
        ge[k][l]    = trial[k][l] >= RW'(dv[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= STEPS; k++) begin
        vld[k] <= 1'b0;
      end
      done <= 1'b0;
    end else begin
      vld[0] <= in_valid;
      for (int k = 0; k < STEPS; k++) begin
        vld[k+1] <= vld[k];
      end
      done <= vld[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      rem[0][l] <= RW'(num[l] >> OUT_W);
      nlo[0][l] <= num[l][OUT_W-1:0];
      quo[0][l] <= '0;
      ov[0][l]  <= (DET_W+OUT_W)'(num[l]) >= {entry.dmag, OUT_W'(0)};
    end
    neg[0]  <= entry.neg;
    dv[0]   <= entry.dmag;
    dsat[0] <= entry.det_sat;
    sing[0] <= entry.singular;
    for (int k = 0; k < STEPS; k++) begin
      for (int l = 0; l < LANES; l++) begin
        rem[k+1][l] <= ge[k][l] ? trial[k][l] - RW'(dv[k]) : trial[k][l];
        nlo[k+1][l] <= {nlo[k][l][OUT_W-2:0], 1'b0};
        quo[k+1][l] <= {quo[k][l][OUT_W-2:0], ge[k][l]};
      end
      ov[k+1]   <= ov[k];
      neg[k+1]  <= neg[k];
      dv[k+1]   <= dv[k];
      dsat[k+1] <= dsat[k];
      sing[k+1] <= sing[k];
    end
  end

  always_comb begin
    logic [OUT_W-1:0] lim;
    logic [OUT_W-1:0] qs;
    lim = '0;
    qs  = '0;
    for (int l = 0; l < LANES; l++) begin
      lim = {1'b1, (OUT_W-1)'(0)} - OUT_W'(!neg[STEPS][l]);
      qs  = (ov[STEPS][l] || quo[STEPS][l] > lim) ? lim : quo[STEPS][l];
      inv[l] = sing[STEPS] ? '0 : (neg[STEPS][l] ? -qs : qs);
    end
  end

  always_ff @(posedge clk) begin
    res.inv00       <= inv[0];
    res.inv01       <= inv[1];
    res.inv02       <= inv[2];
    res.inv10       <= inv[3];
    res.inv11       <= inv[4];
    res.inv12       <= inv[5];
    res.inv20       <= inv[6];
    res.inv21       <= inv[7];
    res.inv22       <= inv[8];
    res.determinant <= sing[STEPS] ? '0 : dsat[STEPS];
    res.singular    <= sing[STEPS];
  end

endmodule
`default_nettype wire
